[hdl/pgg_pkg.sv]
// Package for the polar Gaussian generator: payload structs, config codes
// and fixed-point constants. No dependencies.
`default_nettype none

package pgg_pkg;

  localparam int NFRAC_BITS_DEF = 12;
  localparam int PAIR_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF  = 4;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 24;

  // round(2 ln 2 * 2^30)
  localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MEAN_VALUE = 8'd0,
    CFG_STD_SCALE  = 8'd1
  } cfg_index_t;

  typedef struct packed {
    logic [15:0] uniform_first;
    logic [15:0] uniform_second;
  } uniform_item_t;

  typedef struct packed {
    logic signed [15:0] normal_std;
    logic signed [31:0] normal_scaled;
    logic               last;
  } result_item_t;

  // accepted pair: coordinates in Q1.15 and squared radius r in Q0.30 (r < 1)
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [29:0]        r;
  } pair_t;

endpackage

`default_nettype wire

[hdl/pgg_fifo.sv]
// Small register queue with combinational head read.
// Used between front and back and as the result queue. No package needed.
`default_nettype none

module pgg_fifo #(
  parameter type item_t = logic,
  parameter int  DEPTH  = 4
) (
  input  wire   clk,
  input  wire   rst_n,
  input  wire   push,
  input  item_t push_data,
  output logic  full,
  input  wire   pop,
  output item_t pop_data,
  output logic  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/pgg_front.sv]
// Front end: maps raw uniform words to Q1.15, forms r = x^2 + y^2 and drops
// pairs outside the open unit disk and the pair at the origin. Depends on pgg_pkg.
`default_nettype none

module pgg_front import pgg_pkg::*; (
  input  uniform_item_t in_data,
  input  wire           in_push,
  input  wire           pair_full,
  output logic          pair_push,
  output pair_t         pair_data
);

  logic signed [15:0] x, y;
  logic [31:0]        r;
  logic               keep;

  // word - 32768 is just the MSB flipped
  assign x = {~in_data.uniform_first[15], in_data.uniform_first[14:0]};
  assign y = {~in_data.uniform_second[15], in_data.uniform_second[14:0]};

  assign r    = 32'(x) * 32'(x) + 32'(y) * 32'(y);
  assign keep = (r != '0) && (r[31:30] == 2'b00);

  assign pair_push   = in_push && !pair_full && keep;
  assign pair_data.x = x;
  assign pair_data.y = y;
  assign pair_data.r = r[29:0];

endmodule

`default_nettype wire

[hdl/pgg_back.sv]
// Back end sequencer: log2 by squaring, shared bit-serial square root,
// restoring divider and the output scaling. Depends on pgg_pkg.
`default_nettype none

module pgg_back import pgg_pkg::*; #(
  parameter int NORMAL_FRAC_BITS = NFRAC_BITS_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  pair_t              pair_data,
  input  wire                pair_empty,
  output logic               pair_pop,
  input  wire signed [23:0]  mean_value,
  input  wire [22:0]         std_scale,
  output result_item_t       res_data,
  output logic               res_push,
  input  wire                res_full
);

  localparam int ZSH = 51 - NORMAL_FRAC_BITS;
  localparam logic [55:0] ZRND = 56'd1 << (50 - NORMAL_FRAC_BITS);
  localparam logic [39:0] PRND = 40'd1 << (NORMAL_FRAC_BITS - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_NORM, ST_LOG, ST_LMUL, ST_SADD, ST_SQRT,
    ST_DIV, ST_ZMUL, ST_ZRND, ST_PMUL, ST_EMIT
  } state_t;

  state_t             state_r;
  logic signed [15:0] x_r, y_r;
  logic [29:0]        r_r;
  logic [30:0]        m_r;
  logic [4:0]         k_r, li_r, cnt_r;
  logic [29:0]        f_r;
  logic [60:0]        prod_f_r;
  logic [63:0]        rem_r, root_r, bit_r;
  logic               phase_r, sel_r;
  logic [22:0]        t_r;
  logic [30:0]        sqrt_r_r;
  logic [31:0]        div_rem_r, q_r;
  logic [54:0]        prod_z_r;
  logic [15:0]        zmag_r;
  logic [39:0]        pm_r;

  logic [61:0] sq;
  logic [31:0] sq_hi;
  logic [29:0] lf;
  logic [4:0]  li;
  logic [35:0] s_val;
  logic [63:0] trial, root_nxt;
  logic        sq_ge;
  logic [32:0] rem2;
  logic        div_ge;
  logic [16:0] mag_x, mag_y;
  logic        neg;
  logic [55:0] zsum, zfull;
  logic [15:0] zcap;
  logic [39:0] pm_nxt;
  logic signed [41:0] spm, ssum;
  logic signed [31:0] scaled;

  assign sq    = {31'd0, m_r} * {31'd0, m_r};
  assign sq_hi = sq[61:30];

  // 2^30 - f wraps to zero when f is zero
  assign lf    = 30'(~f_r + 30'd1);
  assign li    = (f_r == '0) ? k_r : k_r - 5'd1;
  assign s_val = 36'({31'd0, li_r} * {5'd0, TWO_LN2_Q30}) + 36'(prod_f_r[60:30]);

  assign trial    = root_r + bit_r;
  assign sq_ge    = (rem_r >= trial);
  assign root_nxt = sq_ge ? ((root_r >> 1) + bit_r) : (root_r >> 1);

  assign rem2   = {div_rem_r, 1'b0};
  assign div_ge = (rem2 >= {2'b00, sqrt_r_r});

  assign mag_x = x_r[15] ? 17'(-{x_r[15], x_r}) : {1'b0, x_r};
  assign mag_y = y_r[15] ? 17'(-{y_r[15], y_r}) : {1'b0, y_r};
  assign neg   = sel_r ? y_r[15] : x_r[15];

  assign zsum  = {1'b0, prod_z_r} + ZRND;
  assign zfull = zsum >> ZSH;
  assign zcap  = neg ? 16'd32768 : 16'd32767;

  assign pm_nxt = (({24'd0, zmag_r} * {17'd0, std_scale}) + PRND) >> NORMAL_FRAC_BITS;

  assign spm    = neg ? -$signed({2'b00, pm_r}) : $signed({2'b00, pm_r});
  assign ssum   = spm + 42'(mean_value);
  assign scaled = (ssum > 42'sd2147483647)  ? 32'sh7fffffff :
                  (ssum < -42'sd2147483648) ? 32'sh80000000 : ssum[31:0];

  assign pair_pop = (state_r == ST_IDLE) && !pair_empty;
  assign res_push = (state_r == ST_EMIT) && !res_full;

  assign res_data.normal_std    = neg ? 16'(-zmag_r) : zmag_r;
  assign res_data.normal_scaled = scaled;
  assign res_data.last          = sel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (!pair_empty) begin
            x_r     <= pair_data.x;
            y_r     <= pair_data.y;
            r_r     <= pair_data.r;
            m_r     <= {1'b0, pair_data.r};
            k_r     <= '0;
            state_r <= ST_NORM;
          end
        end
        ST_NORM: begin
          if (m_r[30]) begin
            cnt_r   <= 5'd29;
            f_r     <= '0;
            state_r <= ST_LOG;
          end else begin
            m_r <= {m_r[29:0], 1'b0};
            k_r <= k_r + 5'd1;
          end
        end
        ST_LOG: begin
          // one fraction bit of log2(m) per squaring
          m_r <= sq_hi[31] ? sq_hi[31:1] : sq_hi[30:0];
          f_r <= {f_r[28:0], sq_hi[31]};
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == '0) begin
            state_r <= ST_LMUL;
          end
        end
        ST_LMUL: begin
          prod_f_r <= {31'd0, lf} * {30'd0, TWO_LN2_Q30};
          li_r     <= li;
          state_r  <= ST_SADD;
        end
        ST_SADD: begin
          rem_r   <= {18'd0, s_val, 10'd0};
          root_r  <= '0;
          bit_r   <= 64'd1 << 62;
          cnt_r   <= 5'd31;
          phase_r <= 1'b0;
          state_r <= ST_SQRT;
        end
        ST_SQRT: begin
          if (cnt_r != '0) begin
            if (sq_ge) begin
              rem_r <= rem_r - trial;
            end
            root_r <= root_nxt;
            bit_r  <= bit_r >> 2;
            cnt_r  <= cnt_r - 5'd1;
          end else if (!phase_r) begin
            t_r     <= root_nxt[22:0];
            rem_r   <= {2'b00, r_r, 32'd0};
            root_r  <= '0;
            bit_r   <= 64'd1 << 62;
            cnt_r   <= 5'd31;
            phase_r <= 1'b1;
          end else begin
            sqrt_r_r  <= root_nxt[30:0];
            sel_r     <= 1'b0;
            div_rem_r <= {mag_x, 15'd0};
            cnt_r     <= 5'd31;
            state_r   <= ST_DIV;
          end
        end
        ST_DIV: begin
          div_rem_r <= div_ge ? 32'(rem2 - {2'b00, sqrt_r_r}) : rem2[31:0];
          q_r       <= {q_r[30:0], div_ge};
          cnt_r     <= cnt_r - 5'd1;
          if (cnt_r == '0) begin
            state_r <= ST_ZMUL;
          end
        end
        ST_ZMUL: begin
          prod_z_r <= {23'd0, q_r} * {32'd0, t_r};
          state_r  <= ST_ZRND;
        end
        ST_ZRND: begin
          zmag_r  <= (zfull > {40'd0, zcap}) ? zcap : zfull[15:0];
          state_r <= ST_PMUL;
        end
        ST_PMUL: begin
          pm_r    <= pm_nxt;
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!res_full) begin
            if (!sel_r) begin
              sel_r     <= 1'b1;
              div_rem_r <= {mag_y, 15'd0};
              cnt_r     <= 5'd31;
              state_r   <= ST_DIV;
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/polar_gaussian_generator_top.sv]
// Polar Gaussian generator. A kept pair at the queue head gives its x sample on the
// result ports and then its y sample (after k = 1..30 normalize shifts). The shared
// sequencer takes a new kept pair only after it has emitted both samples of the last
// one (30 log squarings, two 32-step square roots, two 32-step divisions). Rejected
// pairs never enter the pair queue. Reset (rst_n, synchronous): queues and sequencer
// empty, mean_value 0, std_scale 256. Depends on pgg_pkg, pgg_fifo, pgg_front, pgg_back.
`default_nettype none

module polar_gaussian_generator_top import pgg_pkg::*; #(
  parameter int NORMAL_FRAC_BITS = NFRAC_BITS_DEF,
  parameter int PAIR_DEPTH       = PAIR_DEPTH_DEF,
  parameter int OUT_DEPTH        = OUT_DEPTH_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_push,
  input  uniform_item_t         in_data,
  output logic                  in_full,
  output logic                  out_empty,
  input  wire                   out_pop,
  output result_item_t          out_data,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire [CFG_INDEX_W-1:0] cfg_index,
  input  wire [CFG_DATA_W-1:0]  cfg_data
);

  logic signed [23:0] mean_r;
  logic [22:0]        std_r;

  logic         pair_push, pair_full, pair_pop, pair_empty;
  pair_t        pair_in, pair_out;
  logic         res_push, res_full;
  result_item_t res_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r <= '0;
      std_r  <= 23'd256;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MEAN_VALUE: mean_r <= cfg_data;
        CFG_STD_SCALE:  std_r  <= cfg_data[22:0];
        default: ;
      endcase
    end
  end

  pgg_front u_front (
    .in_data   (in_data),
    .in_push   (in_push),
    .pair_full (pair_full),
    .pair_push (pair_push),
    .pair_data (pair_in)
  );

  assign in_full = pair_full;

  pgg_fifo #(.item_t(pair_t), .DEPTH(PAIR_DEPTH)) u_pair_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (pair_push),
    .push_data (pair_in),
    .full      (pair_full),
    .pop       (pair_pop),
    .pop_data  (pair_out),
    .empty     (pair_empty)
  );

  pgg_back #(.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pair_data  (pair_out),
    .pair_empty (pair_empty),
    .pair_pop   (pair_pop),
    .mean_value (mean_r),
    .std_scale  (std_r),
    .res_data   (res_data),
    .res_push   (res_push),
    .res_full   (res_full)
  );

  pgg_fifo #(.item_t(result_item_t), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .full      (res_full),
    .pop       (out_pop),
    .pop_data  (out_data),
    .empty     (out_empty)
  );

  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  a_pair_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    pair_push |-> !pair_full)
    else $error("pair pushed into full queue");

  // no x sample push directly follows another x sample push
  a_last_after_first: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && !res_data.last) |=> !(res_push && !res_data.last))
    else $error("x sample not followed by y sample");

endmodule

`default_nettype wire
